[src/lzwd_pkg.sv]
// Package for the LZ window decompressor: decode phases, control states,
// status codes and field widths. No dependencies.
`default_nettype none
package lzwd_pkg;

    localparam int WINDOW_DEPTH_DEF = 8192;
    localparam int LANE_COUNT       = 4;
    localparam int LEN_W            = 24;

    typedef enum logic [3:0] {
        PH_FIRST, PH_FLAG, PH_KIND, PH_SCOUNT, PH_LIT,
        PH_SDIST, PH_LHI, PH_LLO, PH_LCOUNT, PH_COPY
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_CREAD, S_CDATA, S_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_DONE    = 3'd1,
        ST_ZCOUNT  = 3'd2,
        ST_BADDIST = 3'd3,
        ST_EXHAUST = 3'd4
    } t_status;

endpackage
`default_nettype wire

[src/lzwd_if.sv]
// Channel interfaces of the LZ window decompressor: input bytes, packed
// results and the length register write. Uses lzwd_pkg.
`default_nettype none
interface lzwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;
    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface lzwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [2:0] byte_count;
    logic       last_of_run;
    logic [2:0] status;
    modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
                    output out_byte3, output byte_count, output last_of_run,
                    output status, input ready);
    modport sink   (input valid, input out_byte0, input out_byte1, input out_byte2,
                    input out_byte3, input byte_count, input last_of_run,
                    input status, output ready);
endinterface

interface lzwd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lzwd_pkg::LEN_W-1:0] output_length;
    modport source (output valid, output output_length, input ready);
    modport sink   (input valid, input output_length, output ready);
endinterface
`default_nettype wire

[src/lz_window_decompressor.sv]
// Top level of the LZ window decompressor: decode sequencer, history RAM
// and result packer. Uses lzwd_pkg and the interfaces in lzwd_if.sv.
//
// One compressed byte is taken per transfer, only while the sequencer is idle.
// After that, the sequencer works in decode steps: a reservoir refill, each
// bit field, a direct byte, and the check at the start and end of a copy.
// Each byte of a match copy goes through decode check, history read, then
// write back and pack. The single history RAM has a registered read, which
// is why the read and the write back are separate steps. A final flush
// state follows when the input byte produced bytes or a status. A full
// output register adds stall cycles. Decompressed bytes leave up to four
// per result. The final result of an input byte has last_of_run set and
// carries the status. After any nonzero status, input bytes are taken and
// dropped until reset. The history needs no clearing after reset.
`default_nettype none
module lz_window_decompressor #(
    parameter int WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lzwd_in_if.sink     i_in,
    lzwd_out_if.source  o_out,
    lzwd_cfg_if.sink    i_cfg
);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int LW = lzwd_pkg::LEN_W;

    logic [7:0] mem [WINDOW_DEPTH];
    logic [7:0] r_rdata;

    lzwd_pkg::t_state  r_state, n_state;
    lzwd_pkg::t_phase  r_phase, n_phase;
    lzwd_pkg::t_status r_spend, n_spend;
    logic [8:0]    r_res, n_res;
    logic [3:0]    r_fill, n_fill;
    logic [7:0]    r_part, n_part;
    logic [12:0]   r_dist, n_dist;
    logic [7:0]    r_cnt, n_cnt;
    logic [LW-1:0] r_bw, n_bw;
    logic [LW-1:0] r_olen, n_olen;
    logic          r_done, n_done;
    logic [7:0]    r_byte, n_byte;
    logic          r_fin, n_fin;
    logic          r_have, n_have;
    logic [7:0]    r_pack [4];
    logic [7:0]    n_pack [4];
    logic [2:0]    r_pcnt, n_pcnt;

    logic          r_ov, n_ov;
    logic [7:0]    r_ob [4];
    logic [7:0]    n_ob [4];
    logic [2:0]    r_ocnt, n_ocnt;
    logic          r_olast, n_olast;
    logic [2:0]    r_ost, n_ost;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    assign i_in.ready  = (r_state == lzwd_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_ov;
    assign o_out.out_byte0   = r_ob[0];
    assign o_out.out_byte1   = r_ob[1];
    assign o_out.out_byte2   = r_ob[2];
    assign o_out.out_byte3   = r_ob[3];
    assign o_out.byte_count  = r_ocnt;
    assign o_out.last_of_run = r_olast;
    assign o_out.status      = r_ost;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_comb begin
        logic              can_push, full_push, emit, end_req, bad;
        logic [7:0]        emit_data;
        logic [2:0]        base;
        logic [3:0]        need, rest;
        logic [15:0]       w;
        logic [12:0]       mdist;
        lzwd_pkg::t_status end_st, st;

        n_state = r_state;  n_phase = r_phase;  n_spend = r_spend;
        n_res = r_res;      n_fill = r_fill;    n_part = r_part;
        n_dist = r_dist;    n_cnt = r_cnt;      n_bw = r_bw;
        n_olen = r_olen;    n_done = r_done;    n_byte = r_byte;
        n_fin = r_fin;      n_have = r_have;    n_pack = r_pack;
        n_pcnt = r_pcnt;
        n_ov = r_ov;        n_ob = r_ob;        n_ocnt = r_ocnt;
        n_olast = r_olast;  n_ost = r_ost;
        mem_we = 1'b0;      mem_re = 1'b0;
        mem_waddr = r_bw[AW-1:0];
        mem_raddr = r_bw[AW-1:0];
        mem_wdata = 8'd0;

        can_push  = !r_ov || o_out.ready;
        full_push = 1'b0;
        emit      = 1'b0;
        emit_data = 8'd0;
        end_req   = 1'b0;
        end_st    = lzwd_pkg::ST_RUN;
        st        = lzwd_pkg::ST_RUN;
        bad       = 1'b0;
        need      = 4'd1;
        rest      = 4'd0;
        w         = {r_part, r_byte};
        mdist     = 13'd0;
        base      = r_pcnt;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        if (i_cfg.valid) begin
            n_olen = i_cfg.output_length;
        end

        case (r_state)
            lzwd_pkg::S_IDLE: begin
                if (i_in.valid && !r_done) begin
                    n_byte  = i_in.data_byte;
                    n_fin   = i_in.final_byte;
                    n_have  = 1'b1;
                    n_state = lzwd_pkg::S_DECODE;
                end
            end
            lzwd_pkg::S_DECODE: begin
                if (r_bw >= r_olen) begin
                    end_req = 1'b1;
                    end_st  = lzwd_pkg::ST_DONE;
                end else begin
                    case (r_phase)
                        lzwd_pkg::PH_FLAG, lzwd_pkg::PH_KIND, lzwd_pkg::PH_SCOUNT: begin
                            need = (r_phase == lzwd_pkg::PH_SCOUNT) ? 4'd2 : 4'd1;
                            if (r_fill >= need) begin
                                rest   = r_fill - need;
                                n_res  = r_res & ((9'd1 << rest) - 9'd1);
                                n_fill = rest;
                                w      = 16'(r_res >> rest);
                                if (r_phase == lzwd_pkg::PH_FLAG) begin
                                    n_phase = w[0] ? lzwd_pkg::PH_LIT : lzwd_pkg::PH_KIND;
                                end else if (r_phase == lzwd_pkg::PH_KIND) begin
                                    n_phase = w[0] ? lzwd_pkg::PH_LHI : lzwd_pkg::PH_SCOUNT;
                                end else begin
                                    n_cnt   = {6'd0, w[1:0]} + 8'd1;
                                    n_phase = lzwd_pkg::PH_SDIST;
                                end
                            end else if (r_have) begin
                                n_res  = {r_res[0], r_byte};
                                n_fill = r_fill + 4'd8;
                                n_have = 1'b0;
                            end else begin
                                end_req = 1'b1;
                            end
                        end
                        lzwd_pkg::PH_COPY: begin
                            if (r_cnt == 8'd0) begin
                                n_phase = lzwd_pkg::PH_FLAG;
                            end else begin
                                n_state = lzwd_pkg::S_CREAD;
                            end
                        end
                        default: begin
                            if (!r_have) begin
                                end_req = 1'b1;
                            end else if (r_phase == lzwd_pkg::PH_FIRST ||
                                         r_phase == lzwd_pkg::PH_LIT) begin
                                if (r_pcnt != 3'd4 || can_push) begin
                                    n_have    = 1'b0;
                                    full_push = (r_pcnt == 3'd4);
                                    emit      = 1'b1;
                                    emit_data = r_byte;
                                    n_phase   = lzwd_pkg::PH_FLAG;
                                end
                            end else begin
                                n_have = 1'b0;
                                case (r_phase)
                                    lzwd_pkg::PH_SDIST: begin
                                        mdist = {5'd0, ~r_byte};
                                        bad   = 1'b1;
                                    end
                                    lzwd_pkg::PH_LHI: begin
                                        n_part  = r_byte;
                                        n_phase = lzwd_pkg::PH_LLO;
                                    end
                                    lzwd_pkg::PH_LLO: begin
                                        mdist = ~w[15:3];
                                        if (w[2:0] != 3'd0) begin
                                            n_cnt = {5'd0, w[2:0]} + 8'd1;
                                            bad   = 1'b1;
                                        end else begin
                                            n_dist  = mdist;
                                            n_phase = lzwd_pkg::PH_LCOUNT;
                                        end
                                    end
                                    lzwd_pkg::PH_LCOUNT: begin
                                        mdist = r_dist;
                                        if (r_byte == 8'd0) begin
                                            end_req = 1'b1;
                                            end_st  = lzwd_pkg::ST_ZCOUNT;
                                        end else begin
                                            n_cnt = r_byte;
                                            bad   = 1'b1;
                                        end
                                    end
                                    default: begin
                                        n_phase = lzwd_pkg::PH_FLAG;
                                    end
                                endcase
                                if (bad) begin
                                    n_dist = mdist;
                                    if (mdist == 13'd0 || {11'd0, mdist} > r_bw) begin
                                        end_req = 1'b1;
                                        end_st  = lzwd_pkg::ST_BADDIST;
                                    end else begin
                                        n_phase = lzwd_pkg::PH_COPY;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            lzwd_pkg::S_CREAD: begin
                if (r_pcnt != 3'd4 || can_push) begin
                    full_push = (r_pcnt == 3'd4);
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_bw - {11'd0, r_dist});
                    n_state   = lzwd_pkg::S_CDATA;
                end
            end
            lzwd_pkg::S_CDATA: begin
                emit      = 1'b1;
                emit_data = r_rdata;
                n_cnt     = r_cnt - 8'd1;
                n_state   = lzwd_pkg::S_DECODE;
            end
            lzwd_pkg::S_FLUSH: begin
                if (can_push) begin
                    n_ov    = 1'b1;
                    n_ob    = r_pack;
                    n_ocnt  = r_pcnt;
                    n_olast = 1'b1;
                    n_ost   = r_spend;
                    n_pack  = '{default: 8'd0};
                    n_pcnt  = 3'd0;
                    n_state = lzwd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lzwd_pkg::S_IDLE;
            end
        endcase

        if (full_push) begin
            n_ov    = 1'b1;
            n_ob    = r_pack;
            n_ocnt  = r_pcnt;
            n_olast = 1'b0;
            n_ost   = lzwd_pkg::ST_RUN;
            n_pack  = '{default: 8'd0};
            n_pcnt  = 3'd0;
            base    = 3'd0;
        end

        if (emit) begin
            mem_we           = 1'b1;
            mem_wdata        = emit_data;
            n_bw             = r_bw + LW'(1);
            n_pack[base[1:0]] = emit_data;
            n_pcnt           = base + 3'd1;
        end

        if (end_req) begin
            st = end_st;
            if (st == lzwd_pkg::ST_RUN && r_fin) begin
                st = lzwd_pkg::ST_EXHAUST;
            end
            if (st != lzwd_pkg::ST_RUN) begin
                n_done = 1'b1;
            end
            n_spend = st;
            if (r_pcnt != 3'd0 || st != lzwd_pkg::ST_RUN) begin
                n_state = lzwd_pkg::S_FLUSH;
            end else begin
                n_state = lzwd_pkg::S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzwd_pkg::S_IDLE;
            r_phase <= lzwd_pkg::PH_FIRST;
            r_spend <= lzwd_pkg::ST_RUN;
            r_res   <= '0;
            r_fill  <= '0;
            r_part  <= '0;
            r_dist  <= '0;
            r_cnt   <= '0;
            r_bw    <= '0;
            r_olen  <= LW'(1);
            r_done  <= 1'b0;
            r_have  <= 1'b0;
            r_pack  <= '{default: 8'd0};
            r_pcnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_spend <= n_spend;
            r_res   <= n_res;
            r_fill  <= n_fill;
            r_part  <= n_part;
            r_dist  <= n_dist;
            r_cnt   <= n_cnt;
            r_bw    <= n_bw;
            r_olen  <= n_olen;
            r_done  <= n_done;
            r_have  <= n_have;
            r_pack  <= n_pack;
            r_pcnt  <= n_pcnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_fin   <= n_fin;
        r_ob    <= n_ob;
        r_ocnt  <= n_ocnt;
        r_olast <= n_olast;
        r_ost   <= n_ost;
    end

endmodule
`default_nettype wire
